// File: rtl/core/sqlss_pkg.sv
// sqlss_pkg: shared types and constants of the sql script statement splitter
// holds the scan mode encoding, byte codes and the beat structs between stages
// no dependencies
package sqlss_pkg;

    // default saturation bound of offsets and line numbers
    localparam longint unsigned MAX_TEXT_BYTES = 64'd1048576;

    // fixed result field widths
    localparam int unsigned FIRST_OFFSET_W = 20;
    localparam int unsigned END_OFFSET_W   = 21;
    localparam int unsigned FIRST_LINE_W   = 21;

    // byte codes
    localparam logic [7:0] CH_BOM0   = 8'hEF;
    localparam logic [7:0] CH_BOM1   = 8'hBB;
    localparam logic [7:0] CH_BOM2   = 8'hBF;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // scan mode, one-hot
    typedef enum logic [7:0] {
        MODE_BOM0    = 8'b0000_0001,
        MODE_BOM1    = 8'b0000_0010,
        MODE_BOM2    = 8'b0000_0100,
        MODE_NORMAL  = 8'b0000_1000,
        MODE_STRING  = 8'b0001_0000,
        MODE_QUOTE   = 8'b0010_0000,
        MODE_DASH    = 8'b0100_0000,
        MODE_COMMENT = 8'b1000_0000
    } t_mode;

    // one input beat
    typedef struct packed {
        logic       end_marker;
        logic [7:0] text_byte;
    } t_item;

    // one result beat
    typedef struct packed {
        logic                      has_statement;
        logic [FIRST_OFFSET_W-1:0] first_offset;
        logic [END_OFFSET_W-1:0]   end_offset;
        logic [FIRST_LINE_W-1:0]   first_line;
        logic                      end_of_text;
        logic                      string_closed;
        logic                      ends_complete;
    } t_result;

endpackage

// File: rtl/core/sqlss_in_reg.sv
// sqlss_in_reg: input register stage of the statement splitter
// holds one accepted beat until the scan stage takes it; uses sqlss_pkg
module sqlss_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sqlss_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_take,
    output sqlss_pkg::t_item o_item
);

    logic             r_valid;
    sqlss_pkg::t_item r_item;

    // free when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/core/sqlss_scan.sv
// sqlss_scan: scan state and per-byte update logic of the statement splitter
// updates mode, counters and piece tracking and forms the result; uses sqlss_pkg
module sqlss_scan #(
    parameter longint unsigned MAX_TEXT_BYTES = sqlss_pkg::MAX_TEXT_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sqlss_pkg::t_item   i_item,
    output logic               o_res_valid,
    output sqlss_pkg::t_result o_res
);

    localparam int unsigned PW = $clog2(MAX_TEXT_BYTES + 1);
    localparam int unsigned FW = $clog2(MAX_TEXT_BYTES);
    localparam logic [PW-1:0] MAX_POS   = PW'(MAX_TEXT_BYTES);
    localparam logic [PW-1:0] MAX_FIRST = PW'(MAX_TEXT_BYTES - 1);

    sqlss_pkg::t_mode r_mode, n_mode;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_line, n_line;
    logic             r_has, n_has;
    logic [FW-1:0]    r_first, n_first;
    logic [PW-1:0]    r_fline, n_fline;
    logic             r_semi, n_semi;

    logic             proc;
    logic             step;
    logic             pre_mark;
    logic [PW-1:0]    mark_off;
    logic [PW-1:0]    pos_dec;
    logic [7:0]       c;
    logic             closed;

    assign c       = i_item.text_byte;
    assign pos_dec = (r_pos != '0) ? r_pos - PW'(1) : '0;

    // next state and result
    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_line      = r_line;
        n_has       = r_has;
        n_first     = r_first;
        n_fline     = r_fline;
        n_semi      = r_semi;
        proc        = 1'b0;
        step        = 1'b0;
        pre_mark    = 1'b0;
        mark_off    = '0;
        closed      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.first_line = sqlss_pkg::FIRST_LINE_W'(1);

        if (i_valid && i_item.end_marker) begin
            // settle held order mark bytes or a lone dash
            case (r_mode)
                sqlss_pkg::MODE_BOM1: begin
                    pre_mark = 1'b1;
                    n_pos    = PW'(1);
                end
                sqlss_pkg::MODE_BOM2: begin
                    pre_mark = 1'b1;
                    n_pos    = PW'(2);
                end
                sqlss_pkg::MODE_DASH: begin
                    pre_mark = 1'b1;
                    mark_off = pos_dec;
                end
                default: begin
                    pre_mark = 1'b0;
                end
            endcase
            if (pre_mark && !n_has) begin
                n_has   = 1'b1;
                n_first = FW'((mark_off < MAX_FIRST) ? mark_off : MAX_FIRST);
                n_fline = r_line;
            end
            closed      = (r_mode != sqlss_pkg::MODE_STRING);
            o_res_valid = 1'b1;
            o_res.has_statement = n_has;
            o_res.first_offset  = n_has ? sqlss_pkg::FIRST_OFFSET_W'(n_first) : '0;
            o_res.end_offset    = sqlss_pkg::END_OFFSET_W'(n_pos);
            o_res.first_line    = n_has ? sqlss_pkg::FIRST_LINE_W'(n_fline)
                                        : sqlss_pkg::FIRST_LINE_W'(1);
            o_res.end_of_text   = 1'b1;
            o_res.string_closed = closed;
            o_res.ends_complete = closed && r_semi && !n_has;
            // back to the start of a new text
            n_mode  = sqlss_pkg::MODE_BOM0;
            n_pos   = '0;
            n_line  = PW'(1);
            n_has   = 1'b0;
            n_first = '0;
            n_fline = PW'(1);
            n_semi  = 1'b0;
        end else if (i_valid) begin
            // mode dispatch
            case (r_mode)
                sqlss_pkg::MODE_BOM0: begin
                    if (c == sqlss_pkg::CH_BOM0) n_mode = sqlss_pkg::MODE_BOM1;
                    else                         proc   = 1'b1;
                end
                sqlss_pkg::MODE_BOM1: begin
                    if (c == sqlss_pkg::CH_BOM1) begin
                        n_mode = sqlss_pkg::MODE_BOM2;
                    end else begin
                        pre_mark = 1'b1;
                        n_pos    = PW'(1);
                        proc     = 1'b1;
                    end
                end
                sqlss_pkg::MODE_BOM2: begin
                    if (c == sqlss_pkg::CH_BOM2) begin
                        n_mode = sqlss_pkg::MODE_NORMAL;
                    end else begin
                        pre_mark = 1'b1;
                        n_pos    = PW'(2);
                        proc     = 1'b1;
                    end
                end
                sqlss_pkg::MODE_STRING: begin
                    if (c == sqlss_pkg::CH_QUOTE) n_mode = sqlss_pkg::MODE_QUOTE;
                    step = 1'b1;
                end
                sqlss_pkg::MODE_QUOTE: begin
                    if (c == sqlss_pkg::CH_QUOTE) begin
                        n_mode = sqlss_pkg::MODE_STRING;
                        step   = 1'b1;
                    end else begin
                        proc = 1'b1;
                    end
                end
                sqlss_pkg::MODE_DASH: begin
                    if (c == sqlss_pkg::CH_DASH) begin
                        n_mode = sqlss_pkg::MODE_COMMENT;
                        step   = 1'b1;
                    end else begin
                        pre_mark = 1'b1;
                        mark_off = pos_dec;
                        proc     = 1'b1;
                    end
                end
                sqlss_pkg::MODE_COMMENT: begin
                    if (c == sqlss_pkg::CH_LF) n_mode = sqlss_pkg::MODE_NORMAL;
                    step = 1'b1;
                end
                sqlss_pkg::MODE_NORMAL: begin
                    proc = 1'b1;
                end
                default: begin
                    proc = 1'b1;
                end
            endcase

            // held bytes become the piece start
            if (pre_mark && !n_has) begin
                n_has   = 1'b1;
                n_first = FW'((mark_off < MAX_FIRST) ? mark_off : MAX_FIRST);
                n_fline = r_line;
            end

            // normal-mode scan of this byte at offset n_pos
            if (proc) begin
                n_mode = sqlss_pkg::MODE_NORMAL;
                step   = 1'b1;
                case (c)
                    sqlss_pkg::CH_QUOTE: begin
                        n_mode = sqlss_pkg::MODE_STRING;
                        if (!n_has) begin
                            n_has   = 1'b1;
                            n_first = FW'((n_pos < MAX_FIRST) ? n_pos : MAX_FIRST);
                            n_fline = r_line;
                        end
                    end
                    sqlss_pkg::CH_DASH: begin
                        n_mode = sqlss_pkg::MODE_DASH;
                    end
                    sqlss_pkg::CH_SEMI: begin
                        o_res_valid = n_has;
                        o_res.has_statement = 1'b1;
                        o_res.first_offset  = sqlss_pkg::FIRST_OFFSET_W'(n_first);
                        o_res.end_offset    = sqlss_pkg::END_OFFSET_W'(n_pos);
                        o_res.first_line    = sqlss_pkg::FIRST_LINE_W'(n_fline);
                        n_semi  = 1'b1;
                        n_has   = 1'b0;
                        n_first = '0;
                        n_fline = PW'(1);
                    end
                    sqlss_pkg::CH_SPACE, sqlss_pkg::CH_TAB,
                    sqlss_pkg::CH_LF, sqlss_pkg::CH_CR: begin
                        n_mode = sqlss_pkg::MODE_NORMAL;
                    end
                    default: begin
                        if (!n_has) begin
                            n_has   = 1'b1;
                            n_first = FW'((n_pos < MAX_FIRST) ? n_pos : MAX_FIRST);
                            n_fline = r_line;
                        end
                    end
                endcase
            end

            // saturating position and line counters
            if (step) begin
                if (n_pos < MAX_POS) n_pos = n_pos + PW'(1);
                if (c == sqlss_pkg::CH_LF && r_line < MAX_POS) n_line = r_line + PW'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sqlss_pkg::MODE_BOM0;
            r_pos   <= '0;
            r_line  <= PW'(1);
            r_has   <= 1'b0;
            r_first <= '0;
            r_fline <= PW'(1);
            r_semi  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_has   <= n_has;
            r_first <= n_first;
            r_fline <= n_fline;
            r_semi  <= n_semi;
        end
    end

`ifndef SYNTHESIS
    // an end marker returns the scanner to its start state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_item.end_marker) |=>
        (r_mode == sqlss_pkg::MODE_BOM0 && r_pos == '0 && !r_semi && !r_has))
        else $error("scan state not cleared after end marker");

    // results only answer an end marker or a semicolon
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_valid &&
        (i_item.end_marker || i_item.text_byte == sqlss_pkg::CH_SEMI)))
        else $error("result without end marker or semicolon");

    // an empty piece keeps its start fields at their cleared values
    a_empty_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_has |-> (r_first == '0 && r_fline == PW'(1)))
        else $error("empty piece holds a start position");

    // counters stay within the saturation bound
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= MAX_POS && r_line <= MAX_POS && r_line != '0))
        else $error("position or line counter out of range");
`endif

endmodule

// File: rtl/core/sqlss_out_reg.sv
// sqlss_out_reg: result register of the statement splitter
// holds a finished result beat until the sink takes it; uses sqlss_pkg
module sqlss_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sqlss_pkg::t_result i_res,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output sqlss_pkg::t_result o_res
);

    logic               r_valid;
    sqlss_pkg::t_result r_res;

    // a new result may enter when empty or when the held one leaves now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/core/sql_script_statement_splitter.sv
// sql_script_statement_splitter: top level of the sql script statement splitter
// depends on sqlss_pkg, sqlss_in_reg, sqlss_scan and sqlss_out_reg
//
// Splits a byte stream of an sql script into statements. Send one byte per
// beat, then one beat with tlast high that carries no byte to end the text.
// A result beat comes out for every semicolon outside strings and comments
// that closes a piece with real content, and always one for the end beat
// (tlast high on the result); after it the block starts over on a new text.
// Each byte passes an input register and one pass of scan logic into a result
// register, from which its result beat is offered; the block takes one byte
// every cycle as long as the result register drains.
// Offsets count from after a leading EF BB BF order mark; offsets and line
// numbers stop at MAX_TEXT_BYTES. No start-up pass is needed after reset.
module sql_script_statement_splitter #(
    parameter longint unsigned MAX_TEXT_BYTES = sqlss_pkg::MAX_TEXT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // end_marker
    // result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [19:0] first_offset, [40:20] end_offset,
                                     // [61:41] first_line, [62] string_closed,
                                     // [63] ends_complete
    output logic        o_m_tuser,   // has_statement
    output logic        o_m_tlast    // end_of_text
);

    sqlss_pkg::t_item   s_item_in;
    sqlss_pkg::t_item   s_item;
    sqlss_pkg::t_result s_res;
    sqlss_pkg::t_result s_res_out;
    logic               s_item_valid;
    logic               s_res_valid;
    logic               s_out_free;
    logic               s_adv;

    assign s_item_in.text_byte  = i_s_tdata;
    assign s_item_in.end_marker = i_s_tlast;

    // a held byte is scanned once the result register can take its outcome
    assign s_adv = s_item_valid && s_out_free;

    // input register
    sqlss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item_in),
        .o_valid (s_item_valid),
        .i_take  (s_adv),
        .o_item  (s_item)
    );

    // scan logic and state
    sqlss_scan #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_adv),
        .i_item      (s_item),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    // result register
    sqlss_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_res_valid),
        .i_res   (s_res),
        .o_free  (s_out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (s_res_out)
    );

    // result beat packing
    assign o_m_tdata = {s_res_out.ends_complete, s_res_out.string_closed,
                        s_res_out.first_line, s_res_out.end_offset,
                        s_res_out.first_offset};
    assign o_m_tuser = s_res_out.has_statement;
    assign o_m_tlast = s_res_out.end_of_text;

endmodule

// File: tb/tb_sql_script_statement_splitter.sv
// tb_sql_script_statement_splitter: self-checking bench for the sql statement splitter
// drives scripts byte by byte, predicts every piece report and compares each result beat
// depends on sqlss_pkg and sql_script_statement_splitter
module tb_sql_script_statement_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [20:0] POS_CAP      = 21'(sqlss_pkg::MAX_TEXT_BYTES);
    localparam int          CALM_BEATS   = 150;
    localparam int          RANDOM_BEATS = 1450;
    localparam int          LIMIT_CYCLES = 400000;

    // one stimulus row, with a hand-typed result where one is given
    typedef struct {
        sqlss_pkg::t_item   beat;
        bit                 typed;
        sqlss_pkg::t_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;    // [7:0] text_byte
    logic        i_s_tlast = 1'b0;     // end_marker
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;            // [19:0] first_offset, [40:20] end_offset,
                                       // [61:41] first_line, [62] string_closed,
                                       // [63] ends_complete
    logic        o_m_tuser;            // has_statement
    logic        o_m_tlast;            // end_of_text

    t_stim_row          script_rows[$];
    sqlss_pkg::t_result pieces_due[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 sink_hold = 0;
    bit                 calm = 1'b0;

    // scanner state of the prediction
    sqlss_pkg::t_mode mode_now;
    logic [20:0]      text_pos;
    logic [20:0]      text_line;
    logic             stmt_open;
    logic [19:0]      stmt_off;
    logic [20:0]      stmt_line;
    logic             saw_semicolon;

    sql_script_statement_splitter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // result beat; offset and line are forced to their idle values without a statement
    function automatic sqlss_pkg::t_result make_result(input bit has, input logic [19:0] fo,
                                            input logic [20:0] eo, input logic [20:0] fl,
                                            input bit eot, input bit cl, input bit cp);
        sqlss_pkg::t_result r;
        r.has_statement = has;
        r.first_offset  = has ? fo : 20'd0;
        r.end_offset    = eo;
        r.first_line    = has ? fl : 21'd1;
        r.end_of_text   = eot;
        r.string_closed = cl;
        r.ends_complete = cp;
        return r;
    endfunction

    function automatic void clear_scan();
        mode_now      = sqlss_pkg::MODE_BOM0;
        text_pos      = 21'd0;
        text_line     = 21'd1;
        stmt_open     = 1'b0;
        stmt_off      = 20'd0;
        stmt_line     = 21'd1;
        saw_semicolon = 1'b0;
    endfunction

    // first useful byte of the current piece
    function automatic void note_content(input logic [20:0] off, input logic [20:0] ln);
        if (stmt_open)
            return;
        stmt_open = 1'b1;
        stmt_off  = (off < POS_CAP - 21'd1) ? off[19:0] : 20'(POS_CAP - 21'd1);
        stmt_line = ln;
    endfunction

    // one byte seen in plain code
    function automatic bit scan_plain(input logic [7:0] c, output sqlss_pkg::t_result r);
        bit got;
        got = 1'b0;
        r   = '0;
        if (c == sqlss_pkg::CH_QUOTE) begin
            note_content(text_pos, text_line);
            mode_now = sqlss_pkg::MODE_STRING;
        end else if (c == sqlss_pkg::CH_DASH) begin
            mode_now = sqlss_pkg::MODE_DASH;
        end else if (c == sqlss_pkg::CH_SEMI) begin
            if (stmt_open) begin
                r   = make_result(1'b1, stmt_off, text_pos, stmt_line, 1'b0, 1'b0, 1'b0);
                got = 1'b1;
            end
            saw_semicolon = 1'b1;
            stmt_open     = 1'b0;
            stmt_off      = 20'd0;
            stmt_line     = 21'd1;
        end else if (c != sqlss_pkg::CH_SPACE && c != sqlss_pkg::CH_TAB &&
                     c != sqlss_pkg::CH_LF && c != sqlss_pkg::CH_CR) begin
            note_content(text_pos, text_line);
        end
        return got;
    endfunction

    // one text byte past the order mark check
    function automatic bit absorb_byte(input logic [7:0] c, output sqlss_pkg::t_result r);
        bit got;
        got = 1'b0;
        r   = '0;
        case (mode_now)
            sqlss_pkg::MODE_STRING: begin
                if (c == sqlss_pkg::CH_QUOTE)
                    mode_now = sqlss_pkg::MODE_QUOTE;
            end
            sqlss_pkg::MODE_QUOTE: begin
                if (c == sqlss_pkg::CH_QUOTE) begin
                    mode_now = sqlss_pkg::MODE_STRING;
                end else begin
                    mode_now = sqlss_pkg::MODE_NORMAL;
                    got = scan_plain(c, r);
                end
            end
            sqlss_pkg::MODE_DASH: begin
                if (c == sqlss_pkg::CH_DASH) begin
                    mode_now = sqlss_pkg::MODE_COMMENT;
                end else begin
                    note_content((text_pos > 21'd0) ? text_pos - 21'd1 : 21'd0, text_line);
                    mode_now = sqlss_pkg::MODE_NORMAL;
                    got = scan_plain(c, r);
                end
            end
            sqlss_pkg::MODE_COMMENT: begin
                if (c == sqlss_pkg::CH_LF)
                    mode_now = sqlss_pkg::MODE_NORMAL;
            end
            default: begin
                mode_now = sqlss_pkg::MODE_NORMAL;
                got = scan_plain(c, r);
            end
        endcase
        if (text_pos < POS_CAP)
            text_pos = text_pos + 21'd1;
        if (c == sqlss_pkg::CH_LF && text_line < POS_CAP)
            text_line = text_line + 21'd1;
        return got;
    endfunction

    // predicted result of one accepted input beat
    function automatic bit split_beat(input sqlss_pkg::t_item it,
                                      output sqlss_pkg::t_result r);
        bit                 got;
        bit                 closed;
        sqlss_pkg::t_result dropped;
        got = 1'b0;
        r   = '0;
        if (it.end_marker) begin
            if (mode_now == sqlss_pkg::MODE_BOM1 || mode_now == sqlss_pkg::MODE_BOM2) begin
                note_content(21'd0, text_line);
                text_pos = (mode_now == sqlss_pkg::MODE_BOM1) ? 21'd1 : 21'd2;
            end else if (mode_now == sqlss_pkg::MODE_DASH) begin
                note_content((text_pos > 21'd0) ? text_pos - 21'd1 : 21'd0, text_line);
            end
            closed = (mode_now != sqlss_pkg::MODE_STRING);
            r = make_result(stmt_open, stmt_off, text_pos, stmt_line, 1'b1, closed,
                            closed && saw_semicolon && !stmt_open);
            clear_scan();
            return 1'b1;
        end
        case (mode_now)
            sqlss_pkg::MODE_BOM0: begin
                if (it.text_byte == sqlss_pkg::CH_BOM0) begin
                    mode_now = sqlss_pkg::MODE_BOM1;
                end else begin
                    mode_now = sqlss_pkg::MODE_NORMAL;
                    got = absorb_byte(it.text_byte, r);
                end
            end
            sqlss_pkg::MODE_BOM1: begin
                if (it.text_byte == sqlss_pkg::CH_BOM1) begin
                    mode_now = sqlss_pkg::MODE_BOM2;
                end else begin
                    mode_now = sqlss_pkg::MODE_NORMAL;
                    void'(absorb_byte(sqlss_pkg::CH_BOM0, dropped));
                    got = absorb_byte(it.text_byte, r);
                end
            end
            sqlss_pkg::MODE_BOM2: begin
                mode_now = sqlss_pkg::MODE_NORMAL;
                if (it.text_byte != sqlss_pkg::CH_BOM2) begin
                    void'(absorb_byte(sqlss_pkg::CH_BOM0, dropped));
                    void'(absorb_byte(sqlss_pkg::CH_BOM1, dropped));
                    got = absorb_byte(it.text_byte, r);
                end
            end
            default: got = absorb_byte(it.text_byte, r);
        endcase
        return got;
    endfunction

    // stimulus table building
    task automatic add_row(input logic [7:0] b, input logic last);
        t_stim_row row;
        row.beat.text_byte  = b;
        row.beat.end_marker = last;
        row.typed           = 1'b0;
        row.want            = '0;
        script_rows.insert(script_rows.size(), row);
    endtask

    task automatic add_typed(input logic [7:0] b, input logic last,
                             input sqlss_pkg::t_result want);
        t_stim_row row;
        row.beat.text_byte  = b;
        row.beat.end_marker = last;
        row.typed           = 1'b1;
        row.want            = want;
        script_rows.insert(script_rows.size(), row);
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return sqlss_pkg::CH_SPACE;
            1:       return sqlss_pkg::CH_TAB;
            2:       return sqlss_pkg::CH_CR;
            default: return sqlss_pkg::CH_LF;
        endcase
    endfunction

    // one random script: mostly sql-like tokens, sometimes pure noise
    task automatic add_random_text();
        int         n_tok;
        int         k;
        int         j;
        int         len;
        int         kind;
        bit         noisy;
        logic [7:0] b;
        noisy = ($urandom_range(0, 6) == 0);
        // leading order mark, whole or cut short
        case ($urandom_range(0, 11))
            0: begin
                add_row(sqlss_pkg::CH_BOM0, 1'b0);
                add_row(sqlss_pkg::CH_BOM1, 1'b0);
                add_row(sqlss_pkg::CH_BOM2, 1'b0);
            end
            1: add_row(sqlss_pkg::CH_BOM0, 1'b0);
            2: begin
                add_row(sqlss_pkg::CH_BOM0, 1'b0);
                add_row(sqlss_pkg::CH_BOM1, 1'b0);
            end
            default: ;
        endcase
        n_tok = $urandom_range(0, 24);
        for (k = 0; k < n_tok; k++) begin
            kind = noisy ? 99 : $urandom_range(0, 11);
            case (kind)
                0, 1, 2: begin
                    len = $urandom_range(1, 6);
                    for (j = 0; j < len; j++)
                        add_row(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                end
                3, 4: add_row(blank_byte(), 1'b0);
                5: begin
                    // quoted string with doubled quotes, rarely left open
                    add_row(sqlss_pkg::CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 8);
                    for (j = 0; j < len; j++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            add_row(sqlss_pkg::CH_QUOTE, 1'b0);
                            add_row(sqlss_pkg::CH_QUOTE, 1'b0);
                        end else begin
                            b = 8'($urandom_range(0, 255));
                            add_row((b == sqlss_pkg::CH_QUOTE) ? sqlss_pkg::CH_SEMI : b,
                                    1'b0);
                        end
                    end
                    if ($urandom_range(0, 9) != 0)
                        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
                end
                6: begin
                    // line comment, sometimes running to the end
                    add_row(sqlss_pkg::CH_DASH, 1'b0);
                    add_row(sqlss_pkg::CH_DASH, 1'b0);
                    len = $urandom_range(0, 10);
                    for (j = 0; j < len; j++) begin
                        b = 8'($urandom_range(0, 255));
                        add_row((b == sqlss_pkg::CH_LF) ? sqlss_pkg::CH_SEMI : b, 1'b0);
                    end
                    if ($urandom_range(0, 5) != 0)
                        add_row(sqlss_pkg::CH_LF, 1'b0);
                end
                7: begin
                    add_row(sqlss_pkg::CH_DASH, 1'b0);
                    if ($urandom_range(0, 1) == 0)
                        add_row(blank_byte(), 1'b0);
                end
                8, 9: add_row(sqlss_pkg::CH_SEMI, 1'b0);
                10: add_row(8'($urandom_range(0, 255)), 1'b0);
                11: begin
                    case ($urandom_range(0, 2))
                        0:       add_row(sqlss_pkg::CH_BOM0, 1'b0);
                        1:       add_row(sqlss_pkg::CH_BOM1, 1'b0);
                        default: add_row(sqlss_pkg::CH_BOM2, 1'b0);
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       add_row(sqlss_pkg::CH_QUOTE, 1'b0);
                        1:       add_row(sqlss_pkg::CH_DASH, 1'b0);
                        2:       add_row(sqlss_pkg::CH_SEMI, 1'b0);
                        3:       add_row(sqlss_pkg::CH_LF, 1'b0);
                        default: add_row(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
            endcase
        end
        add_row(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // result sink with random stall bursts
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sqlss_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pieces_due.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pieces_due.pop_front();
                check_field("has_statement", o_m_tuser, want.has_statement);
                check_field("first_offset", o_m_tdata[19:0], want.first_offset);
                check_field("end_offset", o_m_tdata[40:20], want.end_offset);
                check_field("first_line", o_m_tdata[61:41], want.first_line);
                check_field("end_of_text", o_m_tlast, want.end_of_text);
                check_field("string_closed", o_m_tdata[62], want.string_closed);
                check_field("ends_complete", o_m_tdata[63], want.ends_complete);
            end
        end
    end

    // stimulus
    initial begin
        int                 idx;
        int                 gap;
        int                 directed_rows;
        bit                 got;
        sqlss_pkg::t_result r;
        t_stim_row          row;

        clear_scan();

        // empty text right after reset
        add_typed(8'h00, 1'b1,
                  make_result(1'b0, 20'd0, 21'd0, 21'd1, 1'b1, 1'b1, 1'b0));
        // full order mark, one statement, complete ending
        add_row(sqlss_pkg::CH_BOM0, 1'b0);
        add_row(sqlss_pkg::CH_BOM1, 1'b0);
        add_row(sqlss_pkg::CH_BOM2, 1'b0);
        add_row(8'h61, 1'b0);
        add_typed(sqlss_pkg::CH_SEMI, 1'b0,
                  make_result(1'b1, 20'd0, 21'd1, 21'd1, 1'b0, 1'b0, 1'b0));
        add_typed(8'hFF, 1'b1,
                  make_result(1'b0, 20'd0, 21'd2, 21'd1, 1'b1, 1'b1, 1'b1));
        // partial order mark cut by the end
        add_row(sqlss_pkg::CH_BOM0, 1'b0);
        add_row(sqlss_pkg::CH_BOM1, 1'b0);
        add_row(8'h00, 1'b1);
        // string left open at the end
        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
        add_typed(8'h00, 1'b1,
                  make_result(1'b1, 20'd0, 21'd1, 21'd1, 1'b1, 1'b0, 1'b0));
        // partial order mark, doubled quote, closing quote then semicolon,
        // comment with extreme bytes, lone dash, dash pending at the end
        add_row(sqlss_pkg::CH_BOM0, 1'b0);
        add_row(sqlss_pkg::CH_LF, 1'b0);
        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
        add_row(sqlss_pkg::CH_SEMI, 1'b0);
        add_row(sqlss_pkg::CH_QUOTE, 1'b0);
        add_row(sqlss_pkg::CH_SEMI, 1'b0);
        add_row(sqlss_pkg::CH_DASH, 1'b0);
        add_row(sqlss_pkg::CH_DASH, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(sqlss_pkg::CH_LF, 1'b0);
        add_row(sqlss_pkg::CH_DASH, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(sqlss_pkg::CH_SEMI, 1'b0);
        add_row(sqlss_pkg::CH_SPACE, 1'b0);
        add_row(sqlss_pkg::CH_DASH, 1'b0);
        add_row(8'hA5, 1'b1);
        directed_rows = script_rows.size();

        while (script_rows.size() < directed_rows + RANDOM_BEATS)
            add_random_text();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < script_rows.size(); idx++) begin
            row  = script_rows[idx];
            calm = (idx >= script_rows.size() - CALM_BEATS);
            // source gap burst
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= row.beat.text_byte;
            i_s_tlast  <= row.beat.end_marker;
            @(posedge i_clk);
            while (!o_s_tready)
                @(posedge i_clk);
            // beat accepted at this edge
            got = split_beat(row.beat, r);
            if (row.typed)
                pieces_due.insert(pieces_due.size(), row.want);
            else if (got)
                pieces_due.insert(pieces_due.size(), r);
        end
        i_s_tvalid <= 1'b0;

        while (pieces_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sql_script_statement_splitter.f
rtl/core/sqlss_pkg.sv
rtl/core/sqlss_in_reg.sv
rtl/core/sqlss_scan.sv
rtl/core/sqlss_out_reg.sv
rtl/core/sql_script_statement_splitter.sv
tb/tb_sql_script_statement_splitter.sv
